// ===== rtl/pwli_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
// Used by rtl/piecewise_linear_interpolator.sv; depends on nothing else.

package pwli_pkg;

  localparam int DATA_W     = 32;  // Q16.16 words
  localparam int SLOT_W     = 6;   // entry_index width
  localparam int COUNT_W    = 7;   // point_count width
  localparam int STATUS_W   = 2;
  localparam int IN_TDATA_W = 104; // 6 + 32 + 32 + 32 bits, padded to whole bytes
  localparam int DIV_STEPS  = 32;  // quotient bits, one per cycle
  localparam int STEP_W     = 5;   // counts DIV_STEPS - 1 down to 0

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a beat
    S_FIRST,  // first breakpoint arrives from the tables
    S_LAST,   // last breakpoint arrives, range checks
    S_SCAN,   // one segment tested per cycle
    S_MUL,    // dx * |dy| into the divider registers
    S_DIV,    // restoring division, one quotient bit per cycle
    S_FIN,    // apply quotient to y_i
    S_DONE    // hand the result to the output register
  } state_t;

endpackage

// ===== rtl/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator: breakpoint tables, segment search and a
// sequential multiply/divide datapath. Depends on rtl/pwli_pkg.sv.
//
// Usage. Input beats arrive on s_tvalid/s_tready. s_tuser carries func: a load
// beat writes one (x, y) breakpoint into the slot given by entry_index and
// yields no result; a query beat yields exactly one result beat on
// m_tvalid/m_tready holding the interpolated ordinate and a status code.
// The number of breakpoints in use comes from the cfg channel (cfg_valid,
// cfg_ready, cfg_data); it is always ready and should be written while idle.
//
// Timing. A load beat leaves the sequencer idle, so load beats can be taken
// back to back. A query runs through a small sequencer around one table read
// port, one comparator pair and one shared divider step: two reads for the
// end points, one read per segment tested up to and including the matching
// one, one multiply, 32 divider iterations and the handoff. Queries that fail
// early go straight to the handoff. s_tready is low while a query is being
// worked on. Reset clears the sequencer, the output valid and point_count;
// the tables must be loaded before use. A stalled receiver only holds up a
// query whose result is ready to be handed over.

module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // cfg_data: point_count [6:0]
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwli_pkg::COUNT_W-1:0]      cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: entry_index [5:0], point_x [37:6], point_y [69:38],
  //          query_x [101:70], zero padding [103:102]
  input  logic [pwli_pkg::IN_TDATA_W-1:0]   s_tdata,
  // s_tuser: func [0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: value [31:0]
  output logic [pwli_pkg::DATA_W-1:0]       m_tdata,
  // m_tuser: status [1:0]
  output logic [pwli_pkg::STATUS_W-1:0]     m_tuser
);

  localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CMP_W = (IDX_W > pwli_pkg::COUNT_W) ? IDX_W : pwli_pkg::COUNT_W;
  localparam logic [pwli_pkg::COUNT_W-1:0] MAX_CNT =
    (MAX_POINTS > 127) ? 7'd127 : pwli_pkg::COUNT_W'(MAX_POINTS);

  // Input fields unpacked from the beat.
  logic [pwli_pkg::SLOT_W-1:0]        in_slot;
  logic [pwli_pkg::DATA_W-1:0]        in_px;
  logic [pwli_pkg::DATA_W-1:0]        in_py;
  logic signed [pwli_pkg::DATA_W-1:0] in_qx;

  assign in_slot = s_tdata[5:0];
  assign in_px   = s_tdata[37:6];
  assign in_py   = s_tdata[69:38];
  assign in_qx   = s_tdata[101:70];

  pwli_pkg::state_t state, state_next;

  logic [pwli_pkg::COUNT_W-1:0] point_count;
  logic [pwli_pkg::COUNT_W-1:0] n_use;
  logic [pwli_pkg::COUNT_W-1:0] n_last;

  // Breakpoint tables, one write and one read port each, registered reads.
  logic [pwli_pkg::DATA_W-1:0] abscissa_mem [MAX_POINTS];
  logic [pwli_pkg::DATA_W-1:0] ordinate_mem [MAX_POINTS];
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            rd_idx;
  logic signed [pwli_pkg::DATA_W-1:0] rd_x;
  logic signed [pwli_pkg::DATA_W-1:0] rd_y;

  // Query working registers. xa/ya track the left end of the segment under test.
  logic signed [pwli_pkg::DATA_W-1:0] qx;
  logic signed [pwli_pkg::DATA_W-1:0] xa;
  logic signed [pwli_pkg::DATA_W-1:0] ya;
  logic [pwli_pkg::DATA_W-1:0]        dx;
  logic [pwli_pkg::DATA_W-1:0]        dy_mag;
  logic                               dy_neg;
  logic [pwli_pkg::DATA_W-1:0]        den;

  // Divider: rem holds the partial remainder, quo shifts the dividend out
  // and the quotient in.
  logic [pwli_pkg::DATA_W-1:0]   rem;
  logic [pwli_pkg::DATA_W-1:0]   quo;
  logic [pwli_pkg::STEP_W-1:0]   step;

  logic [pwli_pkg::DATA_W-1:0]   res_value;
  logic [pwli_pkg::STATUS_W-1:0] res_status;

  logic in_fire;
  logic out_free;
  logic seg_hit;
  logic seg_last;
  logic load_ok;

  logic signed [pwli_pkg::DATA_W:0] dy_wide;
  logic signed [pwli_pkg::DATA_W:0] dx_wide;
  logic signed [pwli_pkg::DATA_W:0] den_wide;
  logic [pwli_pkg::DATA_W:0]        dy_abs;
  logic [2*pwli_pkg::DATA_W-1:0]    prod;
  logic [pwli_pkg::DATA_W:0]        trial;
  logic [pwli_pkg::DATA_W:0]        diff;
  logic                             trial_ge;
  logic signed [pwli_pkg::DATA_W:0] fin_sum;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == pwli_pkg::S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign load_ok   = int'(in_slot) < MAX_POINTS;

  assign n_use = (point_count > MAX_CNT) ? MAX_CNT : point_count;

  // Segment test against the entry that just came out of the tables.
  assign seg_hit  = (qx > xa) && (qx <= rd_x);
  assign seg_last = (CMP_W'(rd_idx) == CMP_W'(n_last));

  assign dy_wide  = {rd_y[pwli_pkg::DATA_W-1], rd_y} - {ya[pwli_pkg::DATA_W-1], ya};
  assign dx_wide  = {qx[pwli_pkg::DATA_W-1], qx} - {xa[pwli_pkg::DATA_W-1], xa};
  assign den_wide = {rd_x[pwli_pkg::DATA_W-1], rd_x} - {xa[pwli_pkg::DATA_W-1], xa};
  assign dy_abs   = dy_wide[pwli_pkg::DATA_W] ? (~dy_wide + 1'b1) : dy_wide;

  assign prod = dx * dy_mag;

  // Shared divider step: bring in the next dividend bit, subtract if it fits.
  assign trial    = {rem, quo[pwli_pkg::DATA_W-1]};
  assign diff     = trial - {1'b0, den};
  assign trial_ge = (trial >= {1'b0, den});

  assign fin_sum = dy_neg ? ({ya[pwli_pkg::DATA_W-1], ya} - {1'b0, quo})
                          : ({ya[pwli_pkg::DATA_W-1], ya} + {1'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && s_tuser == pwli_pkg::FUNC_LOAD && load_ok) begin
      abscissa_mem[IDX_W'(in_slot)] <= in_px;
      ordinate_mem[IDX_W'(in_slot)] <= in_py;
    end
    rd_x   <= abscissa_mem[rd_addr];
    rd_y   <= ordinate_mem[rd_addr];
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwli_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    case (state)
      pwli_pkg::S_IDLE: begin
        if (in_fire && s_tuser == pwli_pkg::FUNC_QUERY) begin
          state_next = (n_use < 7'd2) ? pwli_pkg::S_DONE : pwli_pkg::S_FIRST;
        end
      end
      pwli_pkg::S_FIRST: begin
        rd_addr    = IDX_W'(n_last);
        state_next = pwli_pkg::S_LAST;
      end
      pwli_pkg::S_LAST: begin
        rd_addr = IDX_W'(1);
        if (qx < xa || qx > rd_x || qx == xa) begin
          state_next = pwli_pkg::S_DONE;
        end else begin
          state_next = pwli_pkg::S_SCAN;
        end
      end
      pwli_pkg::S_SCAN: begin
        rd_addr = rd_idx + 1'b1;
        if (seg_hit) begin
          state_next = pwli_pkg::S_MUL;
        end else if (seg_last) begin
          state_next = pwli_pkg::S_DONE;
        end
      end
      pwli_pkg::S_MUL: begin
        state_next = pwli_pkg::S_DIV;
      end
      pwli_pkg::S_DIV: begin
        if (step == '0) begin
          state_next = pwli_pkg::S_FIN;
        end
      end
      pwli_pkg::S_FIN: begin
        state_next = pwli_pkg::S_DONE;
      end
      pwli_pkg::S_DONE: begin
        if (out_free) begin
          state_next = pwli_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pwli_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      pwli_pkg::S_IDLE: begin
        qx         <= in_qx;
        n_last     <= n_use - 7'd1;
        res_value  <= '0;
        res_status <= pwli_pkg::STATUS_TOO_FEW;
      end
      pwli_pkg::S_FIRST: begin
        xa <= rd_x;
        ya <= rd_y;
      end
      pwli_pkg::S_LAST: begin
        if (qx < xa || qx > rd_x) begin
          res_status <= pwli_pkg::STATUS_RANGE;
        end else if (qx == xa) begin
          res_value  <= ya;
          res_status <= pwli_pkg::STATUS_OK;
        end
      end
      pwli_pkg::S_SCAN: begin
        if (seg_hit) begin
          dx     <= dx_wide[pwli_pkg::DATA_W-1:0];
          den    <= den_wide[pwli_pkg::DATA_W-1:0];
          dy_mag <= dy_abs[pwli_pkg::DATA_W-1:0];
          dy_neg <= dy_wide[pwli_pkg::DATA_W];
        end else begin
          xa <= rd_x;
          ya <= rd_y;
          // Tables that are not ascending can leave every segment unmatched.
          res_status <= pwli_pkg::STATUS_RANGE;
        end
      end
      pwli_pkg::S_MUL: begin
        // dx <= den, so the high half is below den and the quotient fits 32 bits.
        rem  <= prod[2*pwli_pkg::DATA_W-1:pwli_pkg::DATA_W];
        quo  <= prod[pwli_pkg::DATA_W-1:0];
        step <= pwli_pkg::STEP_W'(pwli_pkg::DIV_STEPS - 1);
      end
      pwli_pkg::S_DIV: begin
        rem  <= trial_ge ? diff[pwli_pkg::DATA_W-1:0] : trial[pwli_pkg::DATA_W-1:0];
        quo  <= {quo[pwli_pkg::DATA_W-2:0], trial_ge};
        step <= step - 1'b1;
      end
      pwli_pkg::S_FIN: begin
        res_value  <= fin_sum[pwli_pkg::DATA_W-1:0];
        res_status <= pwli_pkg::STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == pwli_pkg::S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pwli_pkg::S_DONE && out_free) begin
      m_tdata <= res_value;
      m_tuser <= res_status;
    end
  end

  // A load beat never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == pwli_pkg::FUNC_LOAD) |=> !$rose(m_tvalid))
    else $error("result appeared after a load beat");

  // Any error status carries a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != pwli_pkg::STATUS_OK) |-> (m_tdata == '0))
    else $error("error result with nonzero value");

  // The segment offset never exceeds the segment width, so the quotient fits.
  a_mul_bound: assert property (@(posedge clk) disable iff (rst)
    (state == pwli_pkg::S_MUL) |-> (dx <= den && den != '0))
    else $error("segment offset exceeds segment width");

  // The partial remainder stays below the divisor throughout the division.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == pwli_pkg::S_DIV) |-> (rem < den))
    else $error("divider remainder out of range");

endmodule
